[design/mma_pkg.sv]
// Shared widths, reset values, register indexes and action codes for the
// Montgomery modular ALU. No dependencies; every other file imports it.
`default_nettype none

package mma_pkg;

    // Field and datapath widths.
    localparam int MOD_W     = 30;
    localparam int WORD_W    = 32;
    localparam int OPND_W    = 31;
    localparam int ACT_W     = 4;
    localparam int EXP_W     = 64;
    localparam int INT_W     = 64;
    localparam int CFG_IDX_W = 2;

    // Default number of exponent bits that the power loop walks.
    localparam int EXP_BITS_DEF = 64;

    // Register reset values.
    localparam logic [MOD_W-1:0]  RST_MODULUS = MOD_W'(3);
    localparam logic [WORD_W-1:0] RST_MINV    = 32'hAAAA_AAAB;
    localparam logic [MOD_W-1:0]  RST_R2      = MOD_W'(1);
    localparam logic              RST_SKIP    = 1'b0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINV    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R2      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP    = 2'd3;

    // Action codes of an input item.
    typedef enum logic [ACT_W-1:0] {
        ACT_CONV  = 4'd0,
        ACT_ADD   = 4'd1,
        ACT_SUB   = 4'd2,
        ACT_MUL   = 4'd3,
        ACT_DIV   = 4'd4,
        ACT_POW   = 4'd5,
        ACT_INV   = 4'd6,
        ACT_OUT   = 4'd7,
        ACT_EQUAL = 4'd8,
        ACT_NEG   = 4'd9
    } t_action;

endpackage

`default_nettype wire

[design/mma_mul.sv]
// Shared 32 x 32 multiplier with a registered 64-bit product.
// Depends on mma_pkg for the word width.
`default_nettype none

module mma_mul
    import mma_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [WORD_W-1:0]     i_a,
    input  wire logic [WORD_W-1:0]     i_b,
    output logic      [2*WORD_W-1:0]   o_prod
);

    logic [2*WORD_W-1:0] r_prod;

    // One full product per cycle, available the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_prod <= (2*WORD_W)'(i_a) * (2*WORD_W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[design/mma_div.sv]
// Bit-serial restoring remainder unit: 64-bit magnitude modulo a 30-bit divisor,
// one dividend bit per cycle. Depends on mma_pkg for widths.
`default_nettype none

module mma_div
    import mma_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [INT_W-1:0]   i_dividend,
    input  wire logic [MOD_W-1:0]   i_divisor,
    output logic                    o_done,
    output logic      [MOD_W-1:0]   o_rem
);

    localparam int CNT_W = $clog2(INT_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [INT_W-1:0]   r_dvd;
    logic [MOD_W-1:0]   r_rem;
    logic [MOD_W:0]     w_shift;
    logic [MOD_W:0]     w_trial;

    // Bring in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        w_shift = {r_rem, r_dvd[INT_W-1]};
        w_trial = (w_shift >= {1'b0, i_divisor}) ? (w_shift - {1'b0, i_divisor}) : w_shift;
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_trial[MOD_W-1:0];
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(INT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[design/montgomery_modular_alu.sv]
// Top level of the Montgomery modular ALU: configuration registers, sequencer,
// combinational add/sub/negate/compare logic. Uses mma_pkg, mma_mul and mma_div.
//
//  Channel   Handshake                      Payload
//  -------   ----------------------------   -------------------------------------------
//  command   i_start, o_busy                i_action, i_operand_a, i_operand_b,
//                                           i_exponent, i_integer_value
//  result    o_done (one-cycle strobe)      o_result, o_is_equal
//  config    i_cfg_valid, o_cfg_ready       i_cfg_index, i_cfg_data
//
// Add, sub, negate, equal and unused codes never raise busy; their result strobe
// comes in the cycle after the item is taken. Each Montgomery product passes S_MXY,
// S_MQ, S_MT and S_RED on the one shared multiplier (three products plus the final add).
// Multiply is one product, value out one product and a fold, convert one product after
// S_CVH with the sign fix skipped or after the serial remainder with it. Power and
// inverse square-and-multiply up to the highest set exponent bit; divide adds a product.
// Reset is synchronous and returns the registers to their defaults; results cannot be
// stalled, and the receiver must take each strobe as it comes.
`default_nettype none

module montgomery_modular_alu
    import mma_pkg::*;
#(
    parameter int EXPONENT_BITS = EXP_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    output logic                          o_busy,
    input  wire logic [ACT_W-1:0]         i_action,
    input  wire logic [OPND_W-1:0]        i_operand_a,
    input  wire logic [OPND_W-1:0]        i_operand_b,
    input  wire logic [EXP_W-1:0]         i_exponent,
    input  wire logic signed [INT_W-1:0]  i_integer_value,
    output logic                          o_done,
    output logic      [OPND_W-1:0]        o_result,
    output logic                          o_is_equal,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [WORD_W-1:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_CVH, S_MXY, S_MQ, S_MT, S_RED, S_LOOP, S_CSUB
    } t_state;

    typedef enum logic [2:0] {
        PH_FIN, PH_OUT, PH_ONE, PH_ACC, PH_SQ
    } t_phase;

    // Configuration registers.
    logic [MOD_W-1:0]   r_mod;
    logic [WORD_W-1:0]  r_minv;
    logic [MOD_W-1:0]   r_r2;
    logic               r_skip;

    // Sequencer state and working registers.
    t_state                   r_state;
    t_phase                   r_phase;
    logic                     r_done;
    logic                     r_is_eq;
    logic [OPND_W-1:0]        r_result;
    logic                     r_use_h;
    logic                     r_neg;
    logic                     r_is_div;
    logic [WORD_W-1:0]        r_x;
    logic [WORD_W-1:0]        r_y;
    logic [WORD_W-1:0]        r_vhi;
    logic [WORD_W-1:0]        r_hadd;
    logic [WORD_W-1:0]        r_bhi;
    logic [WORD_W-1:0]        r_acc;
    logic [WORD_W-1:0]        r_sq;
    logic [WORD_W-1:0]        r_a;
    logic [EXPONENT_BITS-1:0] r_exp;

    logic                   w_accept;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [MOD_W-1:0]       w_div_rem;
    logic [MOD_W-1:0]       w_ur;
    logic [INT_W-1:0]       w_mag;
    logic [WORD_W-1:0]      w_m32;
    logic [WORD_W-1:0]      w_m2;
    logic [WORD_W-1:0]      w_r2_32;
    logic [WORD_W-1:0]      w_a32;
    logic [WORD_W-1:0]      w_b32;
    logic [WORD_W-1:0]      w_add_s;
    logic [WORD_W-1:0]      w_add_r;
    logic [WORD_W-1:0]      w_sub_s;
    logic [WORD_W-1:0]      w_sub_r;
    logic [WORD_W-1:0]      w_neg_s;
    logic [WORD_W-1:0]      w_neg_r;
    logic [WORD_W-1:0]      w_csa;
    logic [WORD_W-1:0]      w_csb;
    logic [WORD_W-1:0]      w_csx;
    logic [WORD_W-1:0]      w_one;
    logic [WORD_W-1:0]      w_v_div;
    logic [EXP_W-1:0]       w_inv_e;
    logic [WORD_W-1:0]      w_mul_a;
    logic [WORD_W-1:0]      w_mul_b;
    logic [2*WORD_W-1:0]    w_prod;
    logic [WORD_W-1:0]      w_red;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && (r_state == S_IDLE);
    assign w_div_start = w_accept && (t_action'(i_action) == ACT_CONV) && !r_skip;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= RST_MODULUS;
            r_minv <= RST_MINV;
            r_r2   <= RST_R2;
            r_skip <= RST_SKIP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MODULUS: r_mod  <= i_cfg_data[MOD_W-1:0];
                CFG_MINV:    r_minv <= i_cfg_data;
                CFG_R2:      r_r2   <= i_cfg_data[MOD_W-1:0];
                CFG_SKIP:    r_skip <= i_cfg_data[0];
                default:     r_skip <= r_skip;
            endcase
        end
    end

    // Combinational modular add, subtract, negate, the lazy compare and the value-out fold.
    always_comb begin
        w_m32   = {2'b00, r_mod};
        w_m2    = {1'b0, r_mod, 1'b0};
        w_r2_32 = {2'b00, r_r2};
        w_a32   = {1'b0, i_operand_a};
        w_b32   = {1'b0, i_operand_b};
        w_add_s = w_a32 + w_b32 - w_m2;
        w_add_r = w_add_s[WORD_W-1] ? (w_add_s + w_m2) : w_add_s;
        w_sub_s = w_a32 - w_b32;
        w_sub_r = w_sub_s[WORD_W-1] ? (w_sub_s + w_m2) : w_sub_s;
        w_neg_s = '0 - w_a32;
        w_neg_r = w_neg_s[WORD_W-1] ? (w_neg_s + w_m2) : w_neg_s;
        w_csa   = (w_a32 >= w_m32) ? (w_a32 - w_m32) : w_a32;
        w_csb   = (w_b32 >= w_m32) ? (w_b32 - w_m32) : w_b32;
        w_csx   = (r_x >= w_m32) ? (r_x - w_m32) : r_x;
    end

    // Integer one before the power loop, following the sign fix-up rule.
    always_comb begin
        if (r_skip || (r_mod == MOD_W'(1))) begin
            w_one = WORD_W'(1);
        end else if (r_mod == '0) begin
            w_one = '0;
        end else begin
            w_one = w_m32 + WORD_W'(1);
        end
    end

    // Sign fix-up: magnitude into the remainder unit, truncated remainder plus modulus out.
    assign w_mag   = i_integer_value[INT_W-1] ? ('0 - i_integer_value) : i_integer_value;
    assign w_ur    = (r_mod == '0) ? '0 : w_div_rem;
    assign w_v_div = r_neg ? (w_m32 - {2'b00, w_ur}) : ({2'b00, w_ur} + w_m32);
    assign w_inv_e = {{(EXP_W-WORD_W){1'b0}}, w_m32 - WORD_W'(2)};

    mma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_mod),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            S_CVH: begin
                w_mul_a = r_vhi;
                w_mul_b = w_r2_32;
            end
            S_MQ: begin
                w_mul_a = w_prod[WORD_W-1:0];
                w_mul_b = r_minv;
            end
            S_MT: begin
                w_mul_a = w_prod[WORD_W-1:0];
                w_mul_b = w_m32;
            end
            default: begin
                w_mul_a = r_x;
                w_mul_b = r_y;
            end
        endcase
    end

    mma_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Final step of the reduction: high word plus modulus minus high of q * m.
    assign w_red = r_bhi + w_m32 - w_prod[2*WORD_W-1:WORD_W];

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_is_eq <= 1'b0;
            r_use_h <= 1'b0;
        end else begin
            r_done  <= 1'b0;
            r_is_eq <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_use_h <= 1'b0;
                        unique case (t_action'(i_action))
                            ACT_CONV: begin
                                r_phase <= PH_FIN;
                                r_neg   <= i_integer_value[INT_W-1];
                                r_x     <= i_integer_value[WORD_W-1:0];
                                r_vhi   <= i_integer_value[INT_W-1:WORD_W];
                                r_y     <= w_r2_32;
                                r_state <= r_skip ? S_CVH : S_DIV;
                            end
                            ACT_ADD: begin
                                r_result <= w_add_r[OPND_W-1:0];
                                r_done   <= 1'b1;
                            end
                            ACT_SUB: begin
                                r_result <= w_sub_r[OPND_W-1:0];
                                r_done   <= 1'b1;
                            end
                            ACT_NEG: begin
                                r_result <= w_neg_r[OPND_W-1:0];
                                r_done   <= 1'b1;
                            end
                            ACT_MUL: begin
                                r_x     <= w_a32;
                                r_y     <= w_b32;
                                r_phase <= PH_FIN;
                                r_state <= S_MXY;
                            end
                            ACT_DIV, ACT_POW, ACT_INV: begin
                                r_x      <= w_one;
                                r_y      <= w_r2_32;
                                r_phase  <= PH_ONE;
                                r_a      <= w_a32;
                                r_sq     <= (t_action'(i_action) == ACT_DIV) ? w_b32 : w_a32;
                                r_is_div <= (t_action'(i_action) == ACT_DIV);
                                r_exp    <= (t_action'(i_action) == ACT_POW)
                                            ? i_exponent[EXPONENT_BITS-1:0]
                                            : w_inv_e[EXPONENT_BITS-1:0];
                                r_state  <= S_MXY;
                            end
                            ACT_OUT: begin
                                r_x     <= w_a32;
                                r_y     <= WORD_W'(1);
                                r_phase <= PH_OUT;
                                r_state <= S_MXY;
                            end
                            ACT_EQUAL: begin
                                r_result <= '0;
                                r_is_eq  <= (w_csa == w_csb);
                                r_done   <= 1'b1;
                            end
                            default: begin
                                r_result <= '0;
                                r_done   <= 1'b1;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_x     <= w_v_div;
                        r_state <= S_MXY;
                    end
                end
                S_CVH: begin
                    r_use_h <= 1'b1;
                    r_state <= S_MXY;
                end
                S_MXY: begin
                    // Upper word of v times r_squared, folded into the high half.
                    r_hadd  <= r_use_h ? w_prod[WORD_W-1:0] : '0;
                    r_state <= S_MQ;
                end
                S_MQ: begin
                    r_bhi   <= w_prod[2*WORD_W-1:WORD_W] + r_hadd;
                    r_use_h <= 1'b0;
                    r_state <= S_MT;
                end
                S_MT: begin
                    r_state <= S_RED;
                end
                S_RED: begin
                    unique case (r_phase)
                        PH_FIN: begin
                            r_result <= w_red[OPND_W-1:0];
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                        PH_OUT: begin
                            r_x     <= w_red;
                            r_state <= S_CSUB;
                        end
                        PH_ONE: begin
                            r_acc   <= w_red;
                            r_state <= S_LOOP;
                        end
                        PH_ACC: begin
                            r_acc   <= w_red;
                            r_x     <= r_sq;
                            r_y     <= r_sq;
                            r_phase <= PH_SQ;
                            r_state <= S_MXY;
                        end
                        PH_SQ: begin
                            r_sq    <= w_red;
                            r_exp   <= r_exp >> 1;
                            r_state <= S_LOOP;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_LOOP: begin
                    // Stop once no set exponent bits remain; later squarings are unused.
                    if (r_exp == '0) begin
                        if (r_is_div) begin
                            r_x      <= r_a;
                            r_y      <= r_acc;
                            r_phase  <= PH_FIN;
                            r_is_div <= 1'b0;
                            r_state  <= S_MXY;
                        end else begin
                            r_result <= r_acc[OPND_W-1:0];
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else if (r_exp[0]) begin
                        r_x     <= r_acc;
                        r_y     <= r_sq;
                        r_phase <= PH_ACC;
                        r_state <= S_MXY;
                    end else begin
                        r_x     <= r_sq;
                        r_y     <= r_sq;
                        r_phase <= PH_SQ;
                        r_state <= S_MXY;
                    end
                end
                S_CSUB: begin
                    r_result <= w_csx[OPND_W-1:0];
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_result   = r_result;
    assign o_is_equal = r_is_eq;

endmodule

`default_nettype wire

[design/mma_check.sv]
// Port-level checker for the Montgomery modular ALU and its bind to the top level.
// Depends on mma_pkg for the action codes.
`default_nettype none

module mma_check
    import mma_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_start,
    input wire logic                     o_busy,
    input wire logic [ACT_W-1:0]         i_action,
    input wire logic                     o_done,
    input wire logic [OPND_W-1:0]        o_result,
    input wire logic                     o_is_equal
);

    // No result is shown while a long item is still at work.
    a_no_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_done)
        else $error("result strobe while busy");

    // The equality flag only comes with a result, and then the value is zero.
    a_eq_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_is_equal |-> (o_done && (o_result == '0)))
        else $error("equality flag outside an equal result");

    // Add shows its result in the next cycle and leaves the block free.
    a_add_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_action == ACT_ADD)) |=> (o_done && !o_busy))
        else $error("add did not finish in one cycle");

    // A power item occupies the block on the next cycle.
    a_pow_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_action == ACT_POW)) |=> (o_busy && !o_done))
        else $error("power item did not start the sequencer");

endmodule

bind montgomery_modular_alu mma_check u_mma_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .i_action   (i_action),
    .o_done     (o_done),
    .o_result   (o_result),
    .o_is_equal (o_is_equal)
);

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the Montgomery modular ALU: a directed table, then random
// phases under several register settings. Depends on mma_pkg and montgomery_modular_alu.

module tb_top;
    import mma_pkg::*;

    // Action codes that the block leaves unused.
    localparam bit [ACT_W-1:0] ACT_UNUSED_LO = 4'd10;
    localparam bit [ACT_W-1:0] ACT_UNUSED_HI = 4'd15;

    localparam int EXP_BITS      = EXP_BITS_DEF;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 225;
    localparam int STALL_LIMIT   = 5000;
    localparam int SHOWN_ERRORS  = 100;

    // One row of the directed stimulus: a register write or an item.
    typedef struct packed {
        bit                  is_write;
        bit [CFG_IDX_W-1:0]  reg_index;
        bit [WORD_W-1:0]     reg_data;
        bit [ACT_W-1:0]      action;
        bit [OPND_W-1:0]     a;
        bit [OPND_W-1:0]     b;
        bit [EXP_W-1:0]      exponent;
        bit [INT_W-1:0]      int_value;
        bit                  fixed_check;
        bit [OPND_W-1:0]     fixed_result;
        bit                  fixed_equal;
    } t_row;

    typedef struct packed {
        bit [OPND_W-1:0] result;
        bit              is_equal;
    } t_outcome;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic [ACT_W-1:0]         i_action;
    logic [OPND_W-1:0]        i_operand_a;
    logic [OPND_W-1:0]        i_operand_b;
    logic [EXP_W-1:0]         i_exponent;
    logic signed [INT_W-1:0]  i_integer_value;
    logic                     o_done;
    logic [OPND_W-1:0]        o_result;
    logic                     o_is_equal;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [WORD_W-1:0]        i_cfg_data;

    // Register copies used by the predictor.
    bit [WORD_W-1:0] cfg_mod  = {2'b00, RST_MODULUS};
    bit [WORD_W-1:0] cfg_minv = RST_MINV;
    bit [WORD_W-1:0] cfg_r2   = {2'b00, RST_R2};
    bit              cfg_skip = RST_SKIP;

    t_outcome expected_results[$];
    int       mismatch_count = 0;
    int       results_seen   = 0;
    int       stall_cycles   = 0;
    bit       sender_gaps    = 1'b1;
    t_row     stim_rows [30];

    montgomery_modular_alu u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_action        (i_action),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .i_exponent      (i_exponent),
        .i_integer_value (i_integer_value),
        .o_done          (o_done),
        .o_result        (o_result),
        .o_is_equal      (o_is_equal),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Montgomery reduction with 32-bit wrapping, exactly as the datapath computes it.
    function automatic bit [31:0] redc(bit [63:0] x);
        bit [31:0] q;
        bit [63:0] qm;
        q  = x[31:0] * cfg_minv;
        qm = {32'b0, q} * {32'b0, cfg_mod};
        return x[63:32] + cfg_mod - qm[63:32];
    endfunction

    function automatic bit [31:0] mont_product(bit [31:0] x, bit [31:0] y);
        return redc({32'b0, x} * {32'b0, y});
    endfunction

    // Conversion of a signed integer; the sign fix reduces it into (0, 2m) first.
    function automatic bit [31:0] to_montgomery(bit [63:0] value);
        longint signed sv;
        longint signed rem;
        bit [63:0]     v;
        if (cfg_skip) begin
            v = value;
        end else begin
            sv  = value;
            rem = 0;
            if (cfg_mod != 0) rem = sv % longint'({32'b0, cfg_mod});
            v = rem + longint'({32'b0, cfg_mod});
        end
        return redc(v * {32'b0, cfg_r2});
    endfunction

    // Square-and-multiply, lowest exponent bit first, starting from a converted one.
    function automatic bit [31:0] mont_power(bit [31:0] base, bit [63:0] n);
        bit [31:0] acc;
        bit [31:0] sq;
        acc = to_montgomery(64'd1);
        sq  = base;
        if (EXP_BITS < 64) n = n & ((64'd1 << EXP_BITS) - 64'd1);
        for (int i = 0; i < EXP_BITS; i++) begin
            if (n[i]) acc = mont_product(acc, sq);
            sq = mont_product(sq, sq);
        end
        return acc;
    endfunction

    function automatic bit [31:0] lazy_sub(bit [31:0] x, bit [31:0] y);
        bit [31:0] s;
        s = x - y;
        if (s[31]) s = s + (cfg_mod << 1);
        return s;
    endfunction

    function automatic bit [31:0] fold_residue(bit [31:0] x);
        return (x >= cfg_mod) ? x - cfg_mod : x;
    endfunction

    // Expected result of one item under the current register values.
    function automatic t_outcome predict_alu(bit [ACT_W-1:0] act, bit [OPND_W-1:0] a,
                                             bit [OPND_W-1:0] b, bit [EXP_W-1:0] e,
                                             bit [INT_W-1:0] iv);
        bit [31:0] x;
        bit [31:0] y;
        bit [31:0] res;
        bit        eq;
        t_outcome  out;
        x   = {1'b0, a};
        y   = {1'b0, b};
        res = '0;
        eq  = 1'b0;
        case (act)
            ACT_CONV: res = to_montgomery(iv);
            ACT_ADD: begin
                res = x + y - (cfg_mod << 1);
                if (res[31]) res = res + (cfg_mod << 1);
            end
            ACT_SUB:   res = lazy_sub(x, y);
            ACT_MUL:   res = mont_product(x, y);
            ACT_DIV:   res = mont_product(x, mont_power(y, {32'b0, cfg_mod - 32'd2}));
            ACT_POW:   res = mont_power(x, e);
            ACT_INV:   res = mont_power(x, {32'b0, cfg_mod - 32'd2});
            ACT_OUT:   res = fold_residue(redc({32'b0, x}));
            ACT_EQUAL: eq  = (fold_residue(x) == fold_residue(y));
            ACT_NEG:   res = lazy_sub(32'd0, x);
            default: ;
        endcase
        out.result   = res[OPND_W-1:0];
        out.is_equal = eq;
        return out;
    endfunction

    // Inverse modulo 2^32 of an odd value by Newton iteration.
    function automatic bit [31:0] inverse_mod_2_32(bit [31:0] m);
        bit [31:0] x;
        x = m;
        repeat (5) x = x * (32'd2 - m * x);
        return x;
    endfunction

    function automatic bit [31:0] r_squared_of(bit [31:0] m);
        bit [63:0] r;
        r = (64'd1 << 32) % {32'b0, m};
        return 32'((r * r) % {32'b0, m});
    endfunction

    function automatic t_row item_row(bit [ACT_W-1:0] act, bit [OPND_W-1:0] a,
                                      bit [OPND_W-1:0] b, bit [EXP_W-1:0] e,
                                      bit [INT_W-1:0] iv);
        t_row r;
        r           = '0;
        r.action    = act;
        r.a         = a;
        r.b         = b;
        r.exponent  = e;
        r.int_value = iv;
        return r;
    endfunction

    function automatic t_row fixed_row(bit [ACT_W-1:0] act, bit [OPND_W-1:0] a,
                                       bit [OPND_W-1:0] b, bit [OPND_W-1:0] res, bit eq);
        t_row r;
        r              = item_row(act, a, b, '1, '1);
        r.fixed_check  = 1'b1;
        r.fixed_result = res;
        r.fixed_equal  = eq;
        return r;
    endfunction

    function automatic t_row write_row(bit [CFG_IDX_W-1:0] idx, bit [WORD_W-1:0] data);
        t_row r;
        r           = '0;
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_data  = data;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
            $display("%0t: result %0d %s: got %0h, expected %0h",
                     $time, results_seen, what, got, want);
    endtask

    // Offer one item, with random gaps before it, and wait until it is taken.
    task automatic send_item(bit [ACT_W-1:0] act, bit [OPND_W-1:0] a, bit [OPND_W-1:0] b,
                             bit [EXP_W-1:0] e, bit [INT_W-1:0] iv);
        while (sender_gaps && $urandom_range(99) < 38) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_action        <= act;
        i_operand_a     <= a;
        i_operand_b     <= b;
        i_exponent      <= e;
        i_integer_value <= iv;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Stop sending and wait until every pending result has come back.
    task automatic wait_for_drain();
        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [WORD_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODULUS: cfg_mod  = {2'b00, data[MOD_W-1:0]};
            CFG_MINV:    cfg_minv = data;
            CFG_R2:      cfg_r2   = {2'b00, data[MOD_W-1:0]};
            CFG_SKIP:    cfg_skip = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Program all four registers; a consistent set unless the caller asks otherwise.
    task automatic load_setting(bit [31:0] m, bit consistent, bit skip);
        bit [31:0] minv;
        bit [31:0] r2;
        minv = consistent ? inverse_mod_2_32(m) : $urandom;
        r2   = consistent ? r_squared_of(m) : $urandom;
        write_reg(CFG_MODULUS, {2'($urandom), m[MOD_W-1:0]});
        write_reg(CFG_MINV, minv);
        write_reg(CFG_R2, {2'($urandom), r2[MOD_W-1:0]});
        write_reg(CFG_SKIP, {31'($urandom), skip});
    endtask

    // Operands mostly inside [0, 2m), with edges and out-of-range noise.
    function automatic bit [OPND_W-1:0] pick_operand();
        int unsigned r;
        r = $urandom_range(99);
        if (cfg_mod == 0 || r < 10) return OPND_W'($urandom);
        if (r < 15) return '0;
        if (r < 20) return OPND_W'((cfg_mod << 1) - 1);
        return OPND_W'($urandom_range(0, (cfg_mod << 1) - 1));
    endfunction

    task automatic random_item();
        bit [ACT_W-1:0]   act;
        bit [OPND_W-1:0]  a;
        bit [OPND_W-1:0]  b;
        bit [EXP_W-1:0]   e;
        longint signed    iv;
        if ($urandom_range(99) < 4) act = ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
        else act = ACT_W'($urandom_range(ACT_NEG, ACT_CONV));
        a  = pick_operand();
        b  = pick_operand();
        e  = {$urandom, $urandom};
        if ($urandom_range(9) != 0) e = e >> $urandom_range(63);
        iv = {$urandom, $urandom};
        iv = iv >>> $urandom_range(63);
        send_item(act, a, b, e, iv);
        expected_results.push_back(predict_alu(act, a, b, e, iv));
    endtask

    // Result checker: the receiver takes every strobe as it comes.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report_mismatch("with nothing pending", 64'(o_result), '0);
            end else begin
                want = expected_results.pop_front();
                if (o_result !== want.result)
                    report_mismatch("result", 64'(o_result), 64'(want.result));
                if (o_is_equal !== want.is_equal)
                    report_mismatch("is_equal", 64'(o_is_equal), 64'(want.is_equal));
            end
            results_seen++;
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_row        row;
        bit [31:0]   m;
        i_rst_n         <= 1'b0;
        i_start         <= 1'b0;
        i_action        <= '0;
        i_operand_a     <= '0;
        i_operand_b     <= '0;
        i_exponent      <= '0;
        i_integer_value <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;

        // Directed rows: reset registers first, then sign-fix skipped, a zero modulus,
        // and a maximal modulus with registers that do not match it.
        stim_rows = '{
            fixed_row(ACT_ADD, '0, '0, '0, 1'b0),
            item_row(ACT_SUB, '0, '1, '0, '0),
            fixed_row(ACT_NEG, '0, '0, '0, 1'b0),
            fixed_row(ACT_EQUAL, 31'd4, 31'd1, '0, 1'b1),
            fixed_row(ACT_EQUAL, '0, '1, '0, 1'b0),
            fixed_row(ACT_UNUSED_LO, 31'd5, 31'd6, '0, 1'b0),
            fixed_row(ACT_UNUSED_HI, '1, '1, '0, 1'b0),
            item_row(ACT_CONV, '0, '0, '0, 64'h8000_0000_0000_0000),
            item_row(ACT_CONV, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF),
            item_row(ACT_CONV, '0, '0, '0, '1),
            item_row(ACT_MUL, '1, '1, '0, '0),
            item_row(ACT_POW, 31'd4, '0, '1, '0),
            item_row(ACT_POW, 31'd5, '0, '0, '0),
            item_row(ACT_INV, 31'd2, '0, '0, '0),
            item_row(ACT_DIV, 31'd1, 31'd2, '0, '0),
            item_row(ACT_OUT, '1, '0, '0, '0),
            write_row(CFG_SKIP, 32'd1),
            item_row(ACT_CONV, '0, '0, '0, -64'sd5),
            item_row(ACT_POW, 31'd2, '0, 64'd3, '0),
            write_row(CFG_MODULUS, 32'hC000_0000),
            write_row(CFG_SKIP, 32'd0),
            item_row(ACT_CONV, '0, '0, '0, 64'd12345),
            item_row(ACT_INV, 31'd3, '0, '0, '0),
            write_row(CFG_MODULUS, 32'h3FFF_FFFF),
            write_row(CFG_MINV, 32'hFFFF_FFFF),
            write_row(CFG_R2, 32'h3FFF_FFFE),
            item_row(ACT_CONV, '0, '0, '0, '1),
            item_row(ACT_ADD, '1, '1, '0, '0),
            fixed_row(ACT_EQUAL, '1, '1, '0, 1'b1),
            item_row(ACT_NEG, '1, '0, '0, '0)
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.is_write) begin
                wait_for_drain();
                write_reg(row.reg_index, row.reg_data);
            end else begin
                send_item(row.action, row.a, row.b, row.exponent, row.int_value);
                if (row.fixed_check)
                    expected_results.push_back('{row.fixed_result, row.fixed_equal});
                else
                    expected_results.push_back(predict_alu(row.action, row.a, row.b,
                                                           row.exponent, row.int_value));
            end
        end

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_for_drain();
            case (ph)
                0: load_setting(32'd998244353, 1'b1, 1'b0);
                1: load_setting(32'd1, 1'b1, 1'b0);
                2: load_setting(32'h3FFF_FFFF, 1'b1, 1'b1);
                3: load_setting($urandom_range(32'h3FFF_FFFF, 1) | 32'd1, 1'b1, 1'b0);
                4: load_setting($urandom_range(32'h3FFF_FFFF, 1) | 32'd1, 1'b1, 1'b1);
                5: load_setting(32'd3, 1'b1, 1'($urandom));
                6: begin
                    m = $urandom & 32'h3FFF_FFFF;
                    load_setting(m, 1'b0, 1'($urandom));
                end
                default: load_setting($urandom_range(1023, 1) | 32'd1, 1'b1, 1'($urandom));
            endcase
            // One phase runs back to back with no gaps from the sender.
            sender_gaps = (ph != 4);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 2 && i == PHASE_ITEMS / 2) wait_for_drain();
                random_item();
            end
        end

        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
design/mma_pkg.sv
design/mma_mul.sv
design/mma_div.sv
design/montgomery_modular_alu.sv
design/mma_check.sv
tb/sv/tb_top.sv
